// ----- rtl/sdt_pkg.sv -----
// Shared constants, codes and types of the shape distance template pixel unit.
package sdt_pkg;

    localparam int MODE_W     = 2;
    localparam int SIZE_W     = 11;
    localparam int RATIO_W    = 16;
    localparam int PIX_W      = 10;
    localparam int DIST_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEFAULT_MAX_SIZE = 1024;

    localparam logic [MODE_W-1:0] MODE_CIRCLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ELLIPSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_RATIO  = 2'd2;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = 11'd256;
    localparam int                 RATIO_FRAC_W = 8;
    localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(2 ** RATIO_FRAC_W);
    localparam logic [RATIO_W-1:0] RATIO_MIN  = RATIO_W'(1);

    localparam int PROD_W = RATIO_W + PIX_W;
    localparam int SQ_W   = 2 * PIX_W;
    localparam int RSQ_W  = 2 * PROD_W;
    localparam int RAD_W  = RSQ_W + 1;

    localparam int ISQ_ARG_W  = 56;
    localparam int ISQ_ROOT_W = ISQ_ARG_W / 2;
    localparam int ISQ_STEPS  = 2;
    localparam int ISQ_STAGES = ISQ_ROOT_W / ISQ_STEPS;

    localparam int VAL_W       = 20;
    localparam int DIVR_W      = RATIO_FRAC_W;
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = RECIP_SHIFT;

    localparam logic [DIST_W-1:0] OUT_MAX = '1;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_DIRECT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROOT     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIV_RECT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DIV_ELL  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  val;
        logic [DIVR_W-1:0] r8;
    } side_t;

endpackage

// ----- rtl/shape_distance_template_pixel_unit.sv -----
// Top level of the shape distance template pixel unit: config registers and pipeline.
//
//   port group   direction  handshake               request contents
//   cfg          in         cfg_valid / cfg_ready   cfg_index, cfg_data
//   in           in         in_valid / in_stall     pixel_x, pixel_y
//   out          out        out_valid / out_stall   distance_value, saturated
//
// One pixel per clock sustained while out_stall is low; 4 front stages, 14 square
// root stages at two root bits each, 3 divide and output stages.
// Reset clears every valid bit and loads mode 0, size 256, ratio 1.0.
// Each stage loads when empty or when the stage after it loads, so bubbles close up
// behind a stalled output; in_stall rises only when every stage holds a request.
module shape_distance_template_pixel_unit #(
    parameter int MAX_SIZE = sdt_pkg::DEFAULT_MAX_SIZE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sdt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sdt_pkg::PIX_W-1:0]         pixel_x,
    input  logic [sdt_pkg::PIX_W-1:0]         pixel_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sdt_pkg::DIST_W-1:0]        distance_value,
    output logic                              saturated
);

    logic [sdt_pkg::MODE_W-1:0]      mode_reg;
    logic [sdt_pkg::SIZE_W-1:0]      size_reg;
    logic [sdt_pkg::RATIO_W-1:0]     ratio_reg;

    logic                            front_ld;
    logic                            fr_valid;
    logic [sdt_pkg::ISQ_ARG_W-1:0]   fr_arg;
    sdt_pkg::side_t                  fr_side;
    logic                            isq_ld;
    logic                            isq_valid;
    logic [sdt_pkg::ISQ_ROOT_W-1:0]  isq_root;
    sdt_pkg::side_t                  isq_side;
    logic                            dv_ld;

    assign cfg_ready = 1'b1;
    assign in_stall  = !front_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sdt_pkg::MODE_CIRCLE;
            size_reg  <= sdt_pkg::SIZE_RESET;
            ratio_reg <= sdt_pkg::RATIO_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sdt_pkg::CFG_SHAPE_MODE:    mode_reg  <= cfg_data[sdt_pkg::MODE_W-1:0];
                sdt_pkg::CFG_TEMPLATE_SIZE: size_reg  <= cfg_data[sdt_pkg::SIZE_W-1:0];
                sdt_pkg::CFG_ASPECT_RATIO:  ratio_reg <= cfg_data[sdt_pkg::RATIO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sdt_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ld           (front_ld),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .shape_mode      (mode_reg),
        .template_size   (size_reg),
        .aspect_ratio_q8 (ratio_reg),
        .out_valid       (fr_valid),
        .out_ld          (isq_ld),
        .out_arg         (fr_arg),
        .out_side        (fr_side)
    );

    sdt_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ld     (isq_ld),
        .in_arg    (fr_arg),
        .in_side   (fr_side),
        .out_valid (isq_valid),
        .out_ld    (dv_ld),
        .out_root  (isq_root),
        .out_side  (isq_side)
    );

    sdt_divout u_divout (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (isq_valid),
        .in_ld          (dv_ld),
        .in_root        (isq_root),
        .in_side        (isq_side),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distance_value (distance_value),
        .saturated      (saturated)
    );

    // input side can only block when the pipe is full up to the output register
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

    // a result leaving frees a slot all the way back to the input
    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |-> !in_stall)
        else $error("input stalled while output drains");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (distance_value == sdt_pkg::OUT_MAX))
        else $error("saturated result not clamped");

endmodule

// ----- rtl/sdt_front.sv -----
// Front stages: centre offsets, weighted products, squares and root argument.
module sdt_front #(
    parameter int MAX_SIZE = sdt_pkg::DEFAULT_MAX_SIZE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ld,
    input  logic [sdt_pkg::PIX_W-1:0]      pixel_x,
    input  logic [sdt_pkg::PIX_W-1:0]      pixel_y,
    input  logic [sdt_pkg::MODE_W-1:0]     shape_mode,
    input  logic [sdt_pkg::SIZE_W-1:0]     template_size,
    input  logic [sdt_pkg::RATIO_W-1:0]    aspect_ratio_q8,
    output logic                           out_valid,
    input  logic                           out_ld,
    output logic [sdt_pkg::ISQ_ARG_W-1:0]  out_arg,
    output sdt_pkg::side_t                 out_side
);

    localparam int MAXSZ_W = $clog2(MAX_SIZE + 1);
    localparam int CMP_W   = (MAXSZ_W > sdt_pkg::SIZE_W) ? MAXSZ_W : sdt_pkg::SIZE_W;
    localparam logic [CMP_W-1:0] MAX_L = CMP_W'(MAX_SIZE);
    localparam logic [sdt_pkg::PROD_W-1:0] ROUND_HALF =
        sdt_pkg::PROD_W'(2 ** (sdt_pkg::RATIO_FRAC_W - 1));

    logic ld1, ld2, ld3, ld4;

    // stage 1
    logic [CMP_W-1:0]              size_ext, size_clamp;
    logic [sdt_pkg::PIX_W-1:0]     ctr;
    logic [sdt_pkg::PIX_W-1:0]     s1_dx_next, s1_dy_next;
    logic [sdt_pkg::RATIO_W-1:0]   ratio_nz, s1_ratio_next;
    logic                          s1_rect_next, s1_ell_next, s1_small_next;
    logic                          s1_v_reg;
    logic [sdt_pkg::PIX_W-1:0]     s1_dx_reg, s1_dy_reg;
    logic [sdt_pkg::RATIO_W-1:0]   s1_ratio_reg;
    logic                          s1_rect_reg, s1_ell_reg, s1_small_reg;

    // stage 2
    logic [sdt_pkg::PROD_W-1:0]    s2_rdy_next;
    logic [sdt_pkg::SQ_W-1:0]      s2_dx2_next;
    logic                          s2_v_reg;
    logic [sdt_pkg::PIX_W-1:0]     s2_dx_reg, s2_dy_reg;
    logic [sdt_pkg::PROD_W-1:0]    s2_rdy_reg;
    logic [sdt_pkg::SQ_W-1:0]      s2_dx2_reg;
    logic                          s2_rect_reg, s2_ell_reg, s2_small_reg;
    logic [sdt_pkg::DIVR_W-1:0]    s2_r8_reg;

    // stage 3
    logic [sdt_pkg::RSQ_W-1:0]     s3_rdy2_next;
    logic                          xside;
    logic [sdt_pkg::PROD_W-1:0]    rnd;
    logic [sdt_pkg::VAL_W-1:0]     rect_num;
    sdt_pkg::side_t                s3_side_next;
    logic                          s3_v_reg;
    logic [sdt_pkg::SQ_W-1:0]      s3_dx2_reg;
    logic [sdt_pkg::RSQ_W-1:0]     s3_rdy2_reg;
    sdt_pkg::side_t                s3_side_reg;

    // stage 4
    logic [sdt_pkg::RAD_W-1:0]     rad;
    logic [sdt_pkg::ISQ_ARG_W-1:0] s4_arg_next;
    logic                          s4_v_reg;
    logic [sdt_pkg::ISQ_ARG_W-1:0] s4_arg_reg;
    sdt_pkg::side_t                s4_side_reg;

    assign ld4   = !s4_v_reg || out_ld;
    assign ld3   = !s3_v_reg || ld4;
    assign ld2   = !s2_v_reg || ld3;
    assign ld1   = !s1_v_reg || ld2;
    assign in_ld = ld1;

    always_comb
    begin
        size_ext   = CMP_W'(template_size);
        size_clamp = (size_ext > MAX_L) ? MAX_L : size_ext;
        ctr        = size_clamp[sdt_pkg::SIZE_W-1:1];
        s1_dx_next = (pixel_x >= ctr) ? pixel_x - ctr : ctr - pixel_x;
        s1_dy_next = (pixel_y >= ctr) ? pixel_y - ctr : ctr - pixel_y;
        ratio_nz   = (aspect_ratio_q8 == '0) ? sdt_pkg::RATIO_MIN : aspect_ratio_q8;
        s1_rect_next  = (shape_mode == sdt_pkg::MODE_RECT);
        s1_ell_next   = (shape_mode == sdt_pkg::MODE_ELLIPSE);
        // circle and the unused mode run as ellipse with ratio 1.0
        s1_ratio_next = (s1_rect_next || s1_ell_next) ? ratio_nz : sdt_pkg::RATIO_ONE;
        s1_small_next = ~|s1_ratio_next[sdt_pkg::RATIO_W-1:sdt_pkg::RATIO_FRAC_W];
    end

    always_comb
    begin
        s2_rdy_next = sdt_pkg::PROD_W'(s1_ratio_reg) * sdt_pkg::PROD_W'(s1_dy_reg);
        s2_dx2_next = sdt_pkg::SQ_W'(s1_dx_reg) * sdt_pkg::SQ_W'(s1_dx_reg);
    end

    always_comb
    begin
        s3_rdy2_next = sdt_pkg::RSQ_W'(s2_rdy_reg) * sdt_pkg::RSQ_W'(s2_rdy_reg);
        xside = sdt_pkg::PROD_W'({s2_dx_reg, {sdt_pkg::RATIO_FRAC_W{1'b0}}}) >= s2_rdy_reg;
        rnd   = s2_rdy_reg + ROUND_HALF;
        rect_num = sdt_pkg::VAL_W'({s2_dx_reg, {(sdt_pkg::RATIO_FRAC_W + 1){1'b0}}})
                 + sdt_pkg::VAL_W'(s2_r8_reg);
        s3_side_next.r8   = s2_r8_reg;
        s3_side_next.kind = sdt_pkg::KIND_ROOT;
        s3_side_next.val  = '0;
        priority if (s2_rect_reg && !s2_small_reg)
        begin
            s3_side_next.kind = sdt_pkg::KIND_DIRECT;
            s3_side_next.val  = xside ? sdt_pkg::VAL_W'(s2_dx_reg)
                              : sdt_pkg::VAL_W'(rnd[sdt_pkg::RATIO_FRAC_W +: sdt_pkg::DIST_W]);
        end
        else if (s2_rect_reg)
        begin
            if (xside)
            begin
                s3_side_next.kind = sdt_pkg::KIND_DIV_RECT;
                s3_side_next.val  = rect_num;
            end
            else
            begin
                s3_side_next.kind = sdt_pkg::KIND_DIRECT;
                s3_side_next.val  = sdt_pkg::VAL_W'(s2_dy_reg);
            end
        end
        else if (s2_ell_reg && s2_small_reg)
        begin
            s3_side_next.kind = sdt_pkg::KIND_DIV_ELL;
        end
        else
        begin
            s3_side_next.kind = sdt_pkg::KIND_ROOT;
        end
    end

    always_comb
    begin
        rad = sdt_pkg::RAD_W'({s3_dx2_reg, {(2 * sdt_pkg::RATIO_FRAC_W){1'b0}}})
            + sdt_pkg::RAD_W'(s3_rdy2_reg);
        s4_arg_next = sdt_pkg::ISQ_ARG_W'({rad, 2'b00});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_v_reg <= in_valid;
            end
            if (ld2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (ld3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (ld4)
            begin
                s4_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_dx_reg    <= s1_dx_next;
            s1_dy_reg    <= s1_dy_next;
            s1_ratio_reg <= s1_ratio_next;
            s1_rect_reg  <= s1_rect_next;
            s1_ell_reg   <= s1_ell_next;
            s1_small_reg <= s1_small_next;
        end
        if (ld2)
        begin
            s2_dx_reg    <= s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg;
            s2_rdy_reg   <= s2_rdy_next;
            s2_dx2_reg   <= s2_dx2_next;
            s2_rect_reg  <= s1_rect_reg;
            s2_ell_reg   <= s1_ell_reg;
            s2_small_reg <= s1_small_reg;
            s2_r8_reg    <= s1_ratio_reg[sdt_pkg::DIVR_W-1:0];
        end
        if (ld3)
        begin
            s3_dx2_reg  <= s2_dx2_reg;
            s3_rdy2_reg <= s3_rdy2_next;
            s3_side_reg <= s3_side_next;
        end
        if (ld4)
        begin
            s4_arg_reg  <= s4_arg_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    assign out_valid = s4_v_reg;
    assign out_arg   = s4_arg_reg;
    assign out_side  = s4_side_reg;

endmodule

// ----- rtl/sdt_isqrt.sv -----
// Pipelined integer square root, two result bits per stage.
module sdt_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ld,
    input  logic [sdt_pkg::ISQ_ARG_W-1:0]   in_arg,
    input  sdt_pkg::side_t                  in_side,
    output logic                            out_valid,
    input  logic                            out_ld,
    output logic [sdt_pkg::ISQ_ROOT_W-1:0]  out_root,
    output sdt_pkg::side_t                  out_side
);

    localparam int NS = sdt_pkg::ISQ_STAGES;
    localparam int AW = sdt_pkg::ISQ_ARG_W;
    localparam int QW = sdt_pkg::ISQ_ROOT_W;
    localparam int RW = QW + 2;

    logic [NS:0]    ld;
    logic [NS-1:0]  v_reg;
    logic [NS-1:0]  v_in;
    logic [AW-1:0]  arg_in  [NS];
    logic [RW-1:0]  rem_in  [NS];
    logic [QW-1:0]  root_in [NS];
    sdt_pkg::side_t side_in [NS];
    logic [AW-1:0]  arg_reg  [NS];
    logic [RW-1:0]  rem_reg  [NS];
    logic [QW-1:0]  root_reg [NS];
    sdt_pkg::side_t side_reg [NS];

    assign ld[NS] = out_ld;
    assign in_ld  = ld[0];

    assign v_in[0]    = in_valid;
    assign arg_in[0]  = in_arg;
    assign rem_in[0]  = '0;
    assign root_in[0] = '0;
    assign side_in[0] = in_side;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [AW-1:0] arg_next;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] root_next;
        logic [RW-1:0] trial;

        if (s > 0)
        begin : g_link
            assign v_in[s]    = v_reg[s-1];
            assign arg_in[s]  = arg_reg[s-1];
            assign rem_in[s]  = rem_reg[s-1];
            assign root_in[s] = root_reg[s-1];
            assign side_in[s] = side_reg[s-1];
        end

        assign ld[s] = !v_reg[s] || ld[s+1];

        always_comb
        begin
            arg_next  = arg_in[s];
            rem_next  = rem_in[s];
            root_next = root_in[s];
            trial     = '0;
            for (int j = 0; j < sdt_pkg::ISQ_STEPS; j++)
            begin
                rem_next = {rem_next[RW-3:0], arg_next[AW-1 -: 2]};
                arg_next = {arg_next[AW-3:0], 2'b00};
                trial    = {root_next[RW-3:0], 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[QW-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (ld[s])
            begin
                v_reg[s] <= v_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[s])
            begin
                arg_reg[s]  <= arg_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_in[s];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ----- rtl/sdt_divout.sv -----
// Back stages: rounding, reciprocal divide by twice the ratio, saturation, output register.
module sdt_divout (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ld,
    input  logic [sdt_pkg::ISQ_ROOT_W-1:0]  in_root,
    input  sdt_pkg::side_t                  in_side,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sdt_pkg::DIST_W-1:0]      distance_value,
    output logic                            saturated
);

    localparam int VW = sdt_pkg::VAL_W;
    localparam int PW = sdt_pkg::VAL_W + sdt_pkg::RECIP_W;
    localparam logic [sdt_pkg::ISQ_ROOT_W:0] ROOT_BIAS =
        (sdt_pkg::ISQ_ROOT_W + 1)'(2 ** sdt_pkg::RATIO_FRAC_W);

    // ceil(2^(shift-1) / r): exact floor of n / (2r) for the numerators seen here
    logic [sdt_pkg::RECIP_W-1:0] recip_rom [2 ** sdt_pkg::DIVR_W];

    for (genvar g = 0; g < 2 ** sdt_pkg::DIVR_W; g++)
    begin : g_recip
        localparam int DIVISOR = (g == 0) ? 1 : g;
        localparam longint RECIP_VAL =
            (longint'(2) ** (sdt_pkg::RECIP_SHIFT - 1) + DIVISOR - 1) / DIVISOR;
        assign recip_rom[g] = sdt_pkg::RECIP_W'(RECIP_VAL);
    end

    logic ld1, ld2, ld3;

    logic [sdt_pkg::ISQ_ROOT_W:0]  root_up;
    logic [VW-1:0]                 ell_num;
    logic [VW-1:0]                 d1_num_next, d1_direct_next;
    logic                          d1_div_next;
    logic                          d1_v_reg, d1_div_reg;
    logic [VW-1:0]                 d1_num_reg, d1_direct_reg;
    logic [sdt_pkg::RECIP_W-1:0]   d1_recip_reg;

    logic [PW-1:0]                 d2_prod_next;
    logic                          d2_v_reg, d2_div_reg;
    logic [PW-1:0]                 d2_prod_reg;
    logic [VW-1:0]                 d2_direct_reg;

    logic [VW-1:0]                 res;
    logic                          sat_next;
    logic [sdt_pkg::DIST_W-1:0]    dist_next;
    logic                          out_v_reg, sat_reg;
    logic [sdt_pkg::DIST_W-1:0]    dist_reg;

    assign ld3   = !out_v_reg || !out_stall;
    assign ld2   = !d2_v_reg || ld3;
    assign ld1   = !d1_v_reg || ld2;
    assign in_ld = ld1;

    always_comb
    begin
        root_up = (sdt_pkg::ISQ_ROOT_W + 1)'(in_root) + ROOT_BIAS;
        ell_num = VW'(in_root) + VW'(in_side.r8);
        d1_num_next    = '0;
        d1_direct_next = '0;
        d1_div_next    = 1'b0;
        unique case (in_side.kind)
            sdt_pkg::KIND_DIRECT:
            begin
                d1_direct_next = in_side.val;
            end
            sdt_pkg::KIND_ROOT:
            begin
                d1_direct_next = root_up[sdt_pkg::RATIO_FRAC_W + 1 +: VW];
            end
            sdt_pkg::KIND_DIV_RECT:
            begin
                d1_div_next = 1'b1;
                d1_num_next = in_side.val;
            end
            sdt_pkg::KIND_DIV_ELL:
            begin
                d1_div_next = 1'b1;
                d1_num_next = ell_num;
            end
        endcase
    end

    assign d2_prod_next = PW'(d1_num_reg) * PW'(d1_recip_reg);

    always_comb
    begin
        res       = d2_div_reg ? d2_prod_reg[sdt_pkg::RECIP_SHIFT +: VW] : d2_direct_reg;
        sat_next  = res > VW'(sdt_pkg::OUT_MAX);
        dist_next = sat_next ? sdt_pkg::OUT_MAX : res[sdt_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_v_reg  <= 1'b0;
            d2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                d1_v_reg <= in_valid;
            end
            if (ld2)
            begin
                d2_v_reg <= d1_v_reg;
            end
            if (ld3)
            begin
                out_v_reg <= d2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            d1_num_reg    <= d1_num_next;
            d1_direct_reg <= d1_direct_next;
            d1_div_reg    <= d1_div_next;
            d1_recip_reg  <= recip_rom[in_side.r8];
        end
        if (ld2)
        begin
            d2_prod_reg   <= d2_prod_next;
            d2_div_reg    <= d1_div_reg;
            d2_direct_reg <= d1_direct_reg;
        end
        if (ld3)
        begin
            dist_reg <= dist_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid      = out_v_reg;
    assign distance_value = dist_reg;
    assign saturated      = sat_reg;

endmodule
